### hw/rtl/trmt_pkg.sv
// Shared constants, types and helpers for the tick-rate and monotonic time block.
package trmt_pkg;

  localparam int unsigned TRMT_INPUT_CLOCK_HZ = 1193182;
  localparam int unsigned TRMT_MIN_RATE_HZ    = 19;
  localparam int unsigned TRMT_RST_RATE_HZ    = 100;
  localparam int unsigned TRMT_RST_FAST_HZ    = 1000;
  localparam int unsigned TRMT_NS_PER_SEC     = 1000000000;

  localparam int unsigned TRMT_CFG_W    = 21;
  localparam int unsigned TRMT_REQ_W    = 32;
  localparam int unsigned TRMT_DVD_W    = 30;
  localparam int unsigned TRMT_PERIOD_W = 26;
  localparam int unsigned TRMT_RELOAD_W = 16;
  localparam int unsigned TRMT_VOTE_W   = 16;
  localparam int unsigned TRMT_CNT_W    = 64;

  localparam logic [TRMT_VOTE_W-1:0] TRMT_VOTE_MAX = '1;

  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_SET_RATE  = 3'd1,
    MODE_FAST_REQ  = 3'd2,
    MODE_FAST_REL  = 3'd3,
    MODE_FAST_RST  = 3'd4,
    MODE_SCHED_ON  = 3'd5
  } trmt_mode_t;

  typedef enum logic {
    REG_DEFAULT_RATE = 1'b0,
    REG_FAST_RATE    = 1'b1
  } trmt_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START_NS,
    ST_DIV_NS,
    ST_START_CLK,
    ST_DIV_CLK,
    ST_RESULT
  } trmt_state_t;

  // Limits a requested rate to the range the counter can be programmed with.
  function automatic logic [31:0] trmt_clamp(input logic [31:0] f, input logic [31:0] hi);
    logic [31:0] r;
    r = f;
    if (r < 32'(TRMT_MIN_RATE_HZ)) r = 32'(TRMT_MIN_RATE_HZ);
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

### hw/rtl/tick_rate_and_monotonic_time.sv
// Top level: tick counter, monotonic nanosecond time base and tick-rate programming.
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+------------------------------------------------
//   in_      | in_valid / in_ready  | in_mode, in_rate_request_hz
//   out_     | out_valid / out_ready| strobe, reload, rate, ticks, ns, preempt, votes
//   cfg_     | cfg_we               | cfg_index, cfg_wdata
//
// An event that does not program the rate goes from its transfer to ST_RESULT and is
// placed in the output register from there once the output is free to take it.
// An event that programs the rate passes through ST_START_NS, ST_DIV_NS, ST_START_CLK,
// ST_DIV_CLK and ST_RESULT: the shared divider runs 30 steps for the period and
// 30 steps for the reload value, one bit per cycle, with start and collect cycles.
// In_ready is low from a transfer until its result has been placed in the output
// register; a new event may be taken while that result still waits to be taken.
// Reset restores a rate of 100 Hz with no votes held and scheduling off.
module tick_rate_and_monotonic_time import trmt_pkg::*; #(
  parameter int unsigned INPUT_CLOCK_HZ = TRMT_INPUT_CLOCK_HZ,
  localparam int unsigned RATE_W = $clog2(INPUT_CLOCK_HZ + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_mode,
  input  logic [TRMT_REQ_W-1:0]    in_rate_request_hz,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_program_strobe,
  output logic [TRMT_RELOAD_W-1:0] out_reload_divisor,
  output logic [RATE_W-1:0]        out_rate_in_effect,
  output logic [TRMT_CNT_W-1:0]    out_tick_total,
  output logic [TRMT_CNT_W-1:0]    out_elapsed_ns,
  output logic                     out_preempt_pulse,
  output logic [TRMT_VOTE_W-1:0]   out_votes_held,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [TRMT_CFG_W-1:0]    cfg_wdata
);

  localparam int unsigned RST_RELOAD = INPUT_CLOCK_HZ / TRMT_RST_RATE_HZ;
  localparam int unsigned RST_PERIOD = TRMT_NS_PER_SEC / TRMT_RST_RATE_HZ;

  trmt_state_t                state_r, state_nxt;
  logic [TRMT_CFG_W-1:0]      dflt_rate_r, fast_rate_r;
  logic [TRMT_CNT_W-1:0]      ticks_r, ticks_nxt;
  logic [TRMT_CNT_W-1:0]      ns_r, ns_nxt;
  logic [RATE_W-1:0]          rate_r, rate_nxt;
  logic [TRMT_PERIOD_W-1:0]   period_r, period_nxt;
  logic [TRMT_RELOAD_W-1:0]   reload_r, reload_nxt;
  logic                       sched_r, sched_nxt;
  logic [TRMT_VOTE_W-1:0]     votes_r, votes_nxt;
  logic                       strobe_r, strobe_nxt;
  logic                       pulse_r, pulse_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       load_out;
  logic                       prog;
  logic [31:0]                prog_src;
  logic [31:0]                prog_rate;
  logic                       div_start;
  logic [TRMT_DVD_W-1:0]      div_dividend;
  logic                       div_done;
  logic [TRMT_DVD_W-1:0]      div_quotient;

  logic                       ostrobe_r;
  logic [TRMT_RELOAD_W-1:0]   oreload_r;
  logic [RATE_W-1:0]          orate_r;
  logic [TRMT_CNT_W-1:0]      oticks_r;
  logic [TRMT_CNT_W-1:0]      ons_r;
  logic                       opulse_r;
  logic [TRMT_VOTE_W-1:0]     ovotes_r;

  assign prog_rate = trmt_clamp(prog_src, 32'(INPUT_CLOCK_HZ));

  trmt_div #(
    .DVD_W (TRMT_DVD_W),
    .DVS_W (RATE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (rate_r),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    state_nxt     = state_r;
    ticks_nxt     = ticks_r;
    ns_nxt        = ns_r;
    rate_nxt      = rate_r;
    period_nxt    = period_r;
    reload_nxt    = reload_r;
    sched_nxt     = sched_r;
    votes_nxt     = votes_r;
    strobe_nxt    = strobe_r;
    pulse_nxt     = pulse_r;
    out_valid_nxt = out_valid_r;
    load_out      = 1'b0;
    prog          = 1'b0;
    prog_src      = in_rate_request_hz;
    div_start     = 1'b0;
    div_dividend  = TRMT_DVD_W'(TRMT_NS_PER_SEC);

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          strobe_nxt = 1'b0;
          pulse_nxt  = 1'b0;
          state_nxt  = ST_RESULT;
          unique case (trmt_mode_t'(in_mode))
            MODE_TICK: begin
              ticks_nxt = ticks_r + 1'b1;
              ns_nxt    = ns_r + TRMT_CNT_W'(period_r);
              pulse_nxt = sched_r;
            end
            MODE_SET_RATE: begin
              prog = 1'b1;
            end
            MODE_FAST_REQ: begin
              if (votes_r != TRMT_VOTE_MAX) begin
                if (votes_r == '0) begin
                  prog     = 1'b1;
                  prog_src = 32'(fast_rate_r);
                end
                votes_nxt = votes_r + 1'b1;
              end
            end
            MODE_FAST_REL: begin
              if (votes_r != '0) begin
                votes_nxt = votes_r - 1'b1;
                if (votes_r == TRMT_VOTE_W'(1)) begin
                  prog     = 1'b1;
                  prog_src = 32'(dflt_rate_r);
                end
              end
            end
            MODE_FAST_RST: begin
              if (votes_r != '0) begin
                votes_nxt = '0;
                prog      = 1'b1;
                prog_src  = 32'(dflt_rate_r);
              end
            end
            MODE_SCHED_ON: begin
              sched_nxt = 1'b1;
            end
            default: begin
            end
          endcase
          if (prog) begin
            rate_nxt   = prog_rate[RATE_W-1:0];
            strobe_nxt = 1'b1;
            state_nxt  = ST_START_NS;
          end
        end
      end
      ST_START_NS: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_NS;
      end
      ST_DIV_NS: begin
        if (div_done) begin
          period_nxt = div_quotient[TRMT_PERIOD_W-1:0];
          state_nxt  = ST_START_CLK;
        end
      end
      ST_START_CLK: begin
        div_start    = 1'b1;
        div_dividend = TRMT_DVD_W'(INPUT_CLOCK_HZ);
        state_nxt    = ST_DIV_CLK;
      end
      ST_DIV_CLK: begin
        if (div_done) begin
          reload_nxt = div_quotient[TRMT_RELOAD_W-1:0];
          state_nxt  = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      dflt_rate_r <= TRMT_CFG_W'(TRMT_RST_RATE_HZ);
      fast_rate_r <= TRMT_CFG_W'(TRMT_RST_FAST_HZ);
      ticks_r     <= '0;
      ns_r        <= '0;
      rate_r      <= RATE_W'(TRMT_RST_RATE_HZ);
      period_r    <= TRMT_PERIOD_W'(RST_PERIOD);
      reload_r    <= TRMT_RELOAD_W'(RST_RELOAD);
      sched_r     <= 1'b0;
      votes_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ticks_r     <= ticks_nxt;
      ns_r        <= ns_nxt;
      rate_r      <= rate_nxt;
      period_r    <= period_nxt;
      reload_r    <= reload_nxt;
      sched_r     <= sched_nxt;
      votes_r     <= votes_nxt;
      if (cfg_we) begin
        unique case (trmt_reg_t'(cfg_index))
          REG_DEFAULT_RATE: dflt_rate_r <= cfg_wdata;
          REG_FAST_RATE:    fast_rate_r <= cfg_wdata;
        endcase
      end
    end
    strobe_r <= strobe_nxt;
    pulse_r  <= pulse_nxt;
    if (load_out) begin
      ostrobe_r <= strobe_r;
      oreload_r <= reload_r;
      orate_r   <= rate_r;
      oticks_r  <= ticks_r;
      ons_r     <= ns_r;
      opulse_r  <= pulse_r;
      ovotes_r  <= votes_r;
    end
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_program_strobe = ostrobe_r;
  assign out_reload_divisor = oreload_r;
  assign out_rate_in_effect = orate_r;
  assign out_tick_total     = oticks_r;
  assign out_elapsed_ns     = ons_r;
  assign out_preempt_pulse  = opulse_r;
  assign out_votes_held     = ovotes_r;

endmodule

### hw/rtl/trmt_div.sv
// Iterative restoring divider shared by the period and reload calculations.
module trmt_div import trmt_pkg::*; #(
  parameter int unsigned DVD_W = TRMT_DVD_W,
  parameter int unsigned DVS_W = 21
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int unsigned STEP_W = $clog2(DVD_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(DVD_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      rem_nxt = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### hw/rtl/trmt_chk.sv
// Port-level checker for the tick-rate block, with its bind to the top level.
module trmt_chk import trmt_pkg::*; #(
  parameter int unsigned RATE_W = 21
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     out_program_strobe,
  input logic [RATE_W-1:0]        out_rate_in_effect,
  input logic [TRMT_CNT_W-1:0]    out_tick_total,
  input logic                     out_preempt_pulse
);

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready stayed high after a transfer");

  a_strobe_excl_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_program_strobe && out_preempt_pulse))
    else $error("programming and preempt reported for the same event");

  a_rate_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rate_in_effect >= RATE_W'(TRMT_MIN_RATE_HZ)))
    else $error("rate in effect below the minimum");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tick_total))
    else $error("stalled result changed or was dropped");

endmodule

bind tick_rate_and_monotonic_time trmt_chk #(.RATE_W(RATE_W)) u_trmt_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_program_strobe (out_program_strobe),
  .out_rate_in_effect (out_rate_in_effect),
  .out_tick_total     (out_tick_total),
  .out_preempt_pulse  (out_preempt_pulse)
);

### verif/tb_tick_rate_and_monotonic_time.sv
// Self-checking testbench for the tick-rate and monotonic time block.
module tb_tick_rate_and_monotonic_time;
  import trmt_pkg::*;

  localparam int unsigned RATE_W = $clog2(TRMT_INPUT_CLOCK_HZ + 1);
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam logic [TRMT_CFG_W-1:0] CFG_ALL_ONES = '1;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASE_ITEMS = 198;
  localparam int unsigned VOTE_PILE = 32;
  localparam int unsigned TAIL_CYCLES = 80;

  typedef struct {
    logic                     strobe;
    logic [TRMT_RELOAD_W-1:0] reload;
    logic [RATE_W-1:0]        rate;
    logic [TRMT_CNT_W-1:0]    ticks;
    logic [TRMT_CNT_W-1:0]    ns;
    logic                     preempt;
    logic [TRMT_VOTE_W-1:0]   votes;
  } tick_result_t;

  class tick_time_scoreboard;
    logic [TRMT_CNT_W-1:0]    ticks;
    logic [TRMT_CNT_W-1:0]    ns;
    logic [RATE_W-1:0]        rate;
    logic [TRMT_PERIOD_W-1:0] period;
    bit                       sched;
    logic [TRMT_VOTE_W-1:0]   votes;
    logic [TRMT_CFG_W-1:0]    default_hz;
    logic [TRMT_CFG_W-1:0]    fast_hz;
    tick_result_t             due_results[$];
    int unsigned              failures;

    function new();
      ticks      = '0;
      ns         = '0;
      rate       = RATE_W'(TRMT_RST_RATE_HZ);
      period     = TRMT_PERIOD_W'(TRMT_NS_PER_SEC / TRMT_RST_RATE_HZ);
      sched      = 1'b0;
      votes      = '0;
      default_hz = TRMT_CFG_W'(TRMT_RST_RATE_HZ);
      fast_hz    = TRMT_CFG_W'(TRMT_RST_FAST_HZ);
      failures   = 0;
    endfunction

    function void write_reg(trmt_reg_t idx, logic [TRMT_CFG_W-1:0] val);
      if (idx == REG_DEFAULT_RATE) begin
        default_hz = val;
      end else begin
        fast_hz = val;
      end
    endfunction

    function void program_rate(logic [31:0] hz);
      logic [31:0] f;
      f = hz;
      if (f < TRMT_MIN_RATE_HZ) f = TRMT_MIN_RATE_HZ;
      if (f > TRMT_INPUT_CLOCK_HZ) f = TRMT_INPUT_CLOCK_HZ;
      rate   = f[RATE_W-1:0];
      period = TRMT_PERIOD_W'(TRMT_NS_PER_SEC / f);
    endfunction

    function void note_event(logic [2:0] mode, logic [31:0] req);
      tick_result_t r;
      r.strobe  = 1'b0;
      r.preempt = 1'b0;
      case (mode)
        MODE_TICK: begin
          ticks     = ticks + 1;
          ns        = ns + TRMT_CNT_W'(period);
          r.preempt = sched;
        end
        MODE_SET_RATE: begin
          program_rate(req);
          r.strobe = 1'b1;
        end
        MODE_FAST_REQ: begin
          if (votes != TRMT_VOTE_MAX) begin
            if (votes == 0) begin
              program_rate(32'(fast_hz));
              r.strobe = 1'b1;
            end
            votes = votes + 1'b1;
          end
        end
        MODE_FAST_REL: begin
          if (votes != 0) begin
            votes = votes - 1'b1;
            if (votes == 0) begin
              program_rate(32'(default_hz));
              r.strobe = 1'b1;
            end
          end
        end
        MODE_FAST_RST: begin
          if (votes != 0) begin
            votes = '0;
            program_rate(32'(default_hz));
            r.strobe = 1'b1;
          end
        end
        MODE_SCHED_ON: sched = 1'b1;
        default: ;
      endcase
      r.reload = TRMT_RELOAD_W'(TRMT_INPUT_CLOCK_HZ / 32'(rate));
      r.rate   = rate;
      r.ticks  = ticks;
      r.ns     = ns;
      r.votes  = votes;
      due_results.push_back(r);
    endfunction

    function void check_result(tick_result_t act);
      tick_result_t e;
      if (due_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result at %0t: rate %0d ticks %0d", $time, act.rate, act.ticks);
        return;
      end
      e = due_results.pop_front();
      if (act.strobe !== e.strobe || act.reload !== e.reload || act.rate !== e.rate ||
          act.ticks !== e.ticks || act.ns !== e.ns || act.preempt !== e.preempt ||
          act.votes !== e.votes) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("mismatch at %0t", $time);
          $display("  exp: strobe %0d reload %0d rate %0d ticks %0d ns %0d preempt %0d votes %0d",
                   e.strobe, e.reload, e.rate, e.ticks, e.ns, e.preempt, e.votes);
          $display("  act: strobe %0d reload %0d rate %0d ticks %0d ns %0d preempt %0d votes %0d",
                   act.strobe, act.reload, act.rate, act.ticks, act.ns, act.preempt, act.votes);
        end
      end
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [2:0]               in_mode = MODE_TICK;
  logic [TRMT_REQ_W-1:0]    in_rate_request_hz = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_program_strobe;
  logic [TRMT_RELOAD_W-1:0] out_reload_divisor;
  logic [RATE_W-1:0]        out_rate_in_effect;
  logic [TRMT_CNT_W-1:0]    out_tick_total;
  logic [TRMT_CNT_W-1:0]    out_elapsed_ns;
  logic                     out_preempt_pulse;
  logic [TRMT_VOTE_W-1:0]   out_votes_held;
  logic                     cfg_we = 1'b0;
  trmt_reg_t                cfg_index = REG_DEFAULT_RATE;
  logic [TRMT_CFG_W-1:0]    cfg_wdata = '0;

  tick_time_scoreboard sb;
  tick_result_t        taken_result;
  bit                  allow_gaps = 1'b1;

  tick_rate_and_monotonic_time u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_rate_request_hz (in_rate_request_hz),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_program_strobe (out_program_strobe),
    .out_reload_divisor (out_reload_divisor),
    .out_rate_in_effect (out_rate_in_effect),
    .out_tick_total     (out_tick_total),
    .out_elapsed_ns     (out_elapsed_ns),
    .out_preempt_pulse  (out_preempt_pulse),
    .out_votes_held     (out_votes_held),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      taken_result.strobe  = out_program_strobe;
      taken_result.reload  = out_reload_divisor;
      taken_result.rate    = out_rate_in_effect;
      taken_result.ticks   = out_tick_total;
      taken_result.ns      = out_elapsed_ns;
      taken_result.preempt = out_preempt_pulse;
      taken_result.votes   = out_votes_held;
      sb.check_result(taken_result);
    end
    out_ready <= allow_gaps ? ($urandom_range(99) >= 32) : 1'b1;
  end

  task automatic send_event(input logic [2:0] mode, input logic [31:0] req);
    while (allow_gaps && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_mode            <= mode;
    in_rate_request_hz <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_event(mode, req);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic [TRMT_CFG_W-1:0] default_hz,
                            input logic [TRMT_CFG_W-1:0] fast_hz);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEFAULT_RATE;
    cfg_wdata <= default_hz;
    @(posedge clk);
    sb.write_reg(REG_DEFAULT_RATE, default_hz);
    cfg_index <= REG_FAST_RATE;
    cfg_wdata <= fast_hz;
    @(posedge clk);
    sb.write_reg(REG_FAST_RATE, fast_hz);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [TRMT_CFG_W-1:0] pick_reg_value();
    case ($urandom_range(3))
      0:       return TRMT_CFG_W'($urandom_range(40));
      1:       return TRMT_CFG_W'($urandom_range(CFG_ALL_ONES, TRMT_INPUT_CLOCK_HZ - 40));
      default: return TRMT_CFG_W'($urandom_range(CFG_ALL_ONES));
    endcase
  endfunction

  initial begin
    logic [2:0]  mode;
    logic [31:0] req;
    int unsigned pick;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values in use, scheduling still off at first; later events turn it on.
    send_event(MODE_TICK, 32'd0);
    send_event(MODE_SET_RATE, 32'd0);
    send_event(MODE_TICK, 32'hFFFF_FFFF);
    send_event(MODE_SET_RATE, 32'hFFFF_FFFF);
    send_event(MODE_TICK, 32'd0);
    send_event(MODE_SET_RATE, 32'd18);
    send_event(MODE_SET_RATE, 32'd19);
    send_event(MODE_SET_RATE, TRMT_INPUT_CLOCK_HZ);
    send_event(MODE_SET_RATE, TRMT_INPUT_CLOCK_HZ + 1);
    send_event(MODE_FAST_REL, 32'd0);
    send_event(MODE_FAST_RST, 32'd0);
    send_event(MODE_FAST_REQ, 32'd0);
    send_event(MODE_FAST_REQ, 32'd0);
    send_event(MODE_TICK, 32'd0);
    send_event(MODE_FAST_REL, 32'd0);
    send_event(MODE_FAST_REL, 32'd0);
    send_event(MODE_FAST_REQ, 32'd0);
    send_event(MODE_FAST_RST, 32'd0);
    send_event(MODE_SPARE_A, 32'd500);
    send_event(MODE_SPARE_B, 32'hFFFF_FFFF);
    send_event(MODE_SCHED_ON, 32'd0);
    send_event(MODE_TICK, 32'd0);
    send_event(MODE_SCHED_ON, 32'd0);
    send_event(MODE_TICK, 32'd0);
    drain();

    // Pile up votes back to back, then release one and reset the rest.
    allow_gaps = 1'b0;
    send_event(MODE_FAST_RST, 32'd0);
    for (int i = 0; i < int'(VOTE_PILE); i++) send_event(MODE_FAST_REQ, $urandom());
    send_event(MODE_FAST_REL, 32'd0);
    send_event(MODE_TICK, 32'd0);
    send_event(MODE_FAST_RST, 32'd0);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       write_regs('0, CFG_ALL_ONES);
        1:       write_regs(TRMT_CFG_W'(TRMT_MIN_RATE_HZ), TRMT_CFG_W'(TRMT_INPUT_CLOCK_HZ));
        2:       write_regs(TRMT_CFG_W'(TRMT_INPUT_CLOCK_HZ), TRMT_CFG_W'(TRMT_MIN_RATE_HZ));
        3:       write_regs(CFG_ALL_ONES, '0);
        default: write_regs(pick_reg_value(), pick_reg_value());
      endcase
      allow_gaps = (p != 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(99);
        if (pick < 38)      mode = MODE_TICK;
        else if (pick < 53) mode = MODE_SET_RATE;
        else if (pick < 68) mode = MODE_FAST_REQ;
        else if (pick < 82) mode = MODE_FAST_REL;
        else if (pick < 87) mode = MODE_FAST_RST;
        else if (pick < 90) mode = MODE_SCHED_ON;
        else if (pick < 95) mode = $urandom_range(1) ? MODE_SPARE_A : MODE_SPARE_B;
        else                mode = MODE_FAST_REQ;
        case ($urandom_range(4))
          0:       req = $urandom();
          1:       req = $urandom_range(30);
          2:       req = $urandom_range(TRMT_INPUT_CLOCK_HZ, TRMT_MIN_RATE_HZ);
          3:       req = $urandom_range(TRMT_INPUT_CLOCK_HZ + 20, TRMT_INPUT_CLOCK_HZ - 20);
          default: req = $urandom_range(5000, TRMT_MIN_RATE_HZ);
        endcase
        send_event(mode, req);
      end
      drain();
    end

    allow_gaps = 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("status: fail");
    $finish;
  end

endmodule
